@@ rtl/bcc_pkg.sv @@
// Package for the button click classifier.
// Holds the shared widths, register defaults, event codes and the structs
// passed between the top level and the press tracker. Depends on nothing.
package bcc_pkg;

  localparam int TIME_WIDTH    = 48;
  localparam int CLICK_WIDTH   = 4;
  localparam int CFG_WIDTH     = 24;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_DOUBLE_CLICK = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_LONG_PRESS   = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_US_RESET     = 24'd50000;
  localparam logic [CFG_WIDTH-1:0] DOUBLE_CLICK_US_RESET = 24'd300000;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_US_RESET   = 24'd1000000;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } bcc_event_e;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_us;
    logic [CFG_WIDTH-1:0] double_click_us;
    logic [CFG_WIDTH-1:0] long_press_us;
  } bcc_cfg_t;

  typedef struct packed {
    bcc_event_e event_res;
    logic       held;
  } bcc_result_t;

endpackage

@@ rtl/bcc_in_if.sv @@
// Input channel of the button click classifier: one pin sample per beat.
// Carries valid, ready, the sampled level and its timestamp. Uses bcc_pkg.
interface bcc_in_if #(
  parameter int TimeWidth = bcc_pkg::TIME_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 level;
  logic [TimeWidth-1:0] now_us;

  modport source (output valid, output level, output now_us, input ready);
  modport sink   (input valid, input level, input now_us, output ready);
endinterface

@@ rtl/bcc_out_if.sv @@
// Output channel of the button click classifier: one result per beat.
// Carries valid, ready, the event code and the debounced held state.
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       held;

  modport source (output valid, output event_res, output held, input ready);
  modport sink   (input valid, input event_res, input held, output ready);
endinterface

@@ rtl/bcc_tracker.sv @@
// Press tracker of the button click classifier: debounce, press and release
// times, click count and classification, updated once per step.
// Depends on bcc_pkg.
module bcc_tracker #(
  parameter int TimeWidth  = bcc_pkg::TIME_WIDTH,
  parameter int ClickWidth = bcc_pkg::CLICK_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 level_i,
  input  logic [TimeWidth-1:0] now_i,
  input  bcc_pkg::bcc_cfg_t    cfg_i,
  output bcc_pkg::bcc_result_t res_o
);
  import bcc_pkg::*;

  localparam int PadWidth = TimeWidth - CFG_WIDTH;

  logic                  prev_level_q, prev_level_d;
  logic [TimeWidth-1:0]  change_time_q, change_time_d;
  logic [TimeWidth-1:0]  press_time_q, press_time_d;
  logic [TimeWidth-1:0]  release_time_q, release_time_d;
  logic [ClickWidth-1:0] clicks_q, clicks_d;
  logic                  long_seen_q, long_seen_d;
  logic                  pressed_q, pressed_d;
  logic                  window_q, window_d;

  logic       change;
  logic       press_edge;
  logic       release_edge;
  logic       long_due;
  logic       class_due;
  bcc_event_e event_d;

  // True when more than limit microseconds lie between since and now.
  function automatic logic over(input logic [TimeWidth-1:0] now,
                                input logic [TimeWidth-1:0] since,
                                input logic [CFG_WIDTH-1:0] limit);
    logic [TimeWidth-1:0] diff;
    diff = now - since;
    return (now > since) && (diff > {{PadWidth{1'b0}}, limit});
  endfunction

  assign change       = (level_i != prev_level_q) &&
                        over(now_i, change_time_q, cfg_i.debounce_us);
  assign press_edge   = change && !level_i;
  assign release_edge = change && level_i;

  // A time that is set to now in this step never counts as elapsed, so the
  // checks below look at the stored times and are masked by the edges.
  assign long_due  = !release_edge && (press_edge || (pressed_q && !long_seen_q)) &&
                     !press_edge && over(now_i, press_time_q, cfg_i.long_press_us);
  assign class_due = !press_edge && !release_edge && window_q && !pressed_q &&
                     over(now_i, release_time_q, cfg_i.double_click_us);

  always_comb begin
    prev_level_d   = prev_level_q;
    change_time_d  = change_time_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    clicks_d       = clicks_q;
    long_seen_d    = long_seen_q;
    pressed_d      = pressed_q;
    window_d       = window_q;
    event_d        = EV_NONE;

    if (change) begin
      change_time_d = now_i;
      prev_level_d  = level_i;
    end
    if (press_edge) begin
      press_time_d = now_i;
      pressed_d    = 1'b1;
      long_seen_d  = 1'b0;
    end
    if (release_edge) begin
      release_time_d = now_i;
      pressed_d      = 1'b0;
      if (!long_seen_q) begin
        if (clicks_q != {ClickWidth{1'b1}}) begin
          clicks_d = clicks_q + ClickWidth'(1);
        end
        window_d = 1'b1;
      end
    end

    if (long_due) begin
      long_seen_d = 1'b1;
      clicks_d    = '0;
      event_d     = EV_LONG;
    end

    if (class_due) begin
      window_d = 1'b0;
      case (clicks_q)
        ClickWidth'(1): event_d = EV_SINGLE;
        ClickWidth'(2): event_d = EV_DOUBLE;
        default:        event_d = EV_NONE;
      endcase
      clicks_d = '0;
    end
  end

  assign res_o.event_res = event_d;
  assign res_o.held      = pressed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q   <= 1'b1;
      change_time_q  <= '0;
      press_time_q   <= '0;
      release_time_q <= '0;
      clicks_q       <= '0;
      long_seen_q    <= 1'b0;
      pressed_q      <= 1'b0;
      window_q       <= 1'b0;
    end else if (step_i) begin
      prev_level_q   <= prev_level_d;
      change_time_q  <= change_time_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      clicks_q       <= clicks_d;
      long_seen_q    <= long_seen_d;
      pressed_q      <= pressed_d;
      window_q       <= window_d;
    end
  end

  // A long press is only reported with the button held, a click class only
  // with it released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.event_res == EV_LONG) |-> res_o.held)
    else $error("long press reported while released");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (res_o.event_res == EV_SINGLE || res_o.event_res == EV_DOUBLE))
    |=> (clicks_q == '0 && !window_q && !pressed_q))
    else $error("click count or window left open after classification");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.event_res == EV_LONG) |=> (long_seen_q && clicks_q == '0))
    else $error("long press not recorded");

endmodule

@@ rtl/button_click_classifier.sv @@
// Top level of the button click classifier: channel handshakes, the
// configuration registers and the result register around bcc_tracker.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if and bcc_tracker.
//
// The block takes one pin sample per clock and gives exactly one result per
// sample: an event (none, single click, double click, long press) and the
// debounced held state after that sample. A sample is captured in an input
// register and, once the result register is empty or being read, passes the
// tracker's three 48-bit subtract-and-compare checks (debounce, long press,
// click window) into the result register, which offers its result on the output.
// The sustained rate is one sample per cycle while the result side keeps
// taking beats. Configuration writes to indexes 0 to 2 set the debounce,
// double-click and long-press times in microseconds; other indexes are ignored.
module button_click_classifier #(
  parameter int TimeWidth  = bcc_pkg::TIME_WIDTH,
  parameter int ClickWidth = bcc_pkg::CLICK_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bcc_in_if.sink                            in_i,
  bcc_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [bcc_pkg::CFG_WIDTH-1:0]     cfg_data_i
);
  import bcc_pkg::*;

  bcc_cfg_t cfg_q;

  logic                 s0_valid_q;
  logic                 s0_level_q;
  logic [TimeWidth-1:0] s0_now_q;

  logic        out_valid_q;
  bcc_result_t out_q;
  bcc_result_t step_res;
  logic        advance;

  // The sample moves on whenever the result register is empty or being read.
  assign advance    = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_us     <= DEBOUNCE_US_RESET;
      cfg_q.double_click_us <= DOUBLE_CLICK_US_RESET;
      cfg_q.long_press_us   <= LONG_PRESS_US_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_DEBOUNCE:     cfg_q.debounce_us     <= cfg_data_i;
        CFG_IDX_DOUBLE_CLICK: cfg_q.double_click_us <= cfg_data_i;
        CFG_IDX_LONG_PRESS:   cfg_q.long_press_us   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_level_q <= in_i.level;
      s0_now_q   <= in_i.now_us;
    end
  end

  bcc_tracker #(
    .TimeWidth  (TimeWidth),
    .ClickWidth (ClickWidth)
  ) u_tracker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .level_i (s0_level_q),
    .now_i   (s0_now_q),
    .cfg_i   (cfg_q),
    .res_o   (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_q.event_res;
  assign out_o.held      = out_q.held;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("stepped sample produced no result beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !advance) |-> !in_i.ready)
    else $error("input taken while the input register is blocked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && out_valid_q && !out_o.ready)
    |=> (s0_valid_q && $stable(s0_now_q) && $stable(s0_level_q)))
    else $error("held sample lost while the result side stalls");

endmodule
